// ----- design/qvr_pkg.sv -----
// ----------------------------------------------------------------------------
// qvr_pkg : shared types and constants for the quaternion vector rotator
// Widths of the quaternion, vector and matrix paths, register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package qvr_pkg;

    localparam int Q_W     = 16;  // quaternion component, Q2.14
    localparam int VEC_W   = 24;  // vector component
    localparam int AXES    = 3;
    localparam int QP_W    = 2 * Q_W;        // quaternion product, Q.28
    localparam int FRAC_W  = 28;             // fraction bits of matrix elements
    localparam int M_W     = QP_W + 2;       // matrix element, holds +-2^32
    localparam int P_W     = M_W + VEC_W;    // element times component
    localparam int ACC_W   = P_W + 2;        // sum of three products
    localparam int RND_W   = ACC_W - FRAC_W; // integer part after rounding

    localparam logic signed [M_W-1:0] M_ONE =
        {{(M_W - FRAC_W - 1){1'b0}}, 1'b1, {FRAC_W{1'b0}}};
    localparam logic signed [ACC_W-1:0] ACC_HALF =
        {{(ACC_W - FRAC_W){1'b0}}, 1'b1, {(FRAC_W - 1){1'b0}}};
    localparam logic signed [VEC_W-1:0] VEC_MAX = {1'b0, {(VEC_W - 1){1'b1}}};
    localparam logic signed [VEC_W-1:0] VEC_MIN = {1'b1, {(VEC_W - 1){1'b0}}};
    localparam logic signed [Q_W-1:0]   Q_UNIT  = 16'sd16384;

    typedef logic signed [Q_W-1:0]   t_quat;
    typedef logic signed [VEC_W-1:0] t_vec;
    typedef logic signed [M_W-1:0]   t_melem;
    typedef t_melem [AXES-1:0]       t_mrow;
    typedef t_mrow  [AXES-1:0]       t_mat;
    typedef t_vec   [AXES-1:0]       t_vec3;

    typedef enum logic [1:0] {
        REG_QI = 2'd0,
        REG_QJ = 2'd1,
        REG_QK = 2'd2,
        REG_QR = 2'd3
    } t_reg_idx;

endpackage

`default_nettype wire

// ----- design/quaternion_vector_rotate.sv -----
// ----------------------------------------------------------------------------
// quaternion_vector_rotate : rotate 3D vectors by a configured quaternion
// Rotation matrix from a Q2.14 quaternion applied to 24-bit vectors.
// ----------------------------------------------------------------------------
// Takes one vector per clock and returns its rotated copy through the two
// lane stages and the output register; a stalled output holds the
// pipeline in place. The three components are computed by three lanes in
// parallel, each one row of the rotation matrix, and the output register
// merges their values and clip flags. The matrix is rebuilt in two register
// stages from the quaternion registers, so the input is not ready after
// reset and every register write until r_mat is rebuilt. The quaternion is
// used as written, no normalization; results round half up and saturate.
`default_nettype none

module quaternion_vector_rotate
    import qvr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [71:0] i_s_axis_tdata,   // vec_x, vec_y, vec_z
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [71:0]      o_m_axis_tdata,   // rot_x, rot_y, rot_z
    output logic             o_m_axis_tuser    // saturated
);

    t_mat             mat;
    logic             mat_busy;
    t_vec3            vec;
    t_vec  [AXES-1:0] lane_val;
    logic  [AXES-1:0] lane_sat;
    logic             pipe_en;
    logic             accept;
    logic             r_v1, r_v2, r_out_valid;
    logic [71:0]      r_tdata;
    logic             r_tuser;

    qvr_matrix u_matrix (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_mat      (mat),
        .o_busy     (mat_busy)
    );

    assign vec     = i_s_axis_tdata;
    assign pipe_en = !r_out_valid || i_m_axis_tready;
    assign accept  = i_s_axis_tvalid && o_s_axis_tready;

    for (genvar r = 0; r < AXES; r++) begin : g_lane
        qvr_lane u_lane (
            .i_clk (i_clk),
            .i_en  (pipe_en),
            .i_row (mat[r]),
            .i_vec (vec),
            .o_val (lane_val[r]),
            .o_sat (lane_sat[r])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (pipe_en) begin
            r_v1        <= accept;
            r_v2        <= r_v1;
            r_out_valid <= r_v2;
        end
    end

    // merge the lanes into one output item
    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_tdata <= lane_val;
            r_tuser <= |lane_sat;
        end
    end

    assign o_s_axis_tready = pipe_en && !mat_busy;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_tdata;
    assign o_m_axis_tuser  = r_tuser;

endmodule

`default_nettype wire

// ----- design/qvr_matrix.sv -----
// ----------------------------------------------------------------------------
// qvr_matrix : quaternion registers and rotation matrix
// Holds the four quaternion registers and rebuilds the 3x3 rotation matrix
// in two register stages; o_busy covers the rebuild after reset or a write.
// ----------------------------------------------------------------------------
`default_nettype none

module qvr_matrix
    import qvr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    output t_mat             o_mat,
    output logic             o_busy
);

    t_quat r_qi, r_qj, r_qk, r_qr;
    logic signed [QP_W-1:0] r_p_ii, r_p_jj, r_p_kk, r_p_ij, r_p_ik, r_p_jk;
    logic signed [QP_W-1:0] r_p_ir, r_p_jr, r_p_kr;
    t_melem e_ii, e_jj, e_kk, e_ij, e_ik, e_jk, e_ir, e_jr, e_kr;
    t_mat   r_mat, n_mat;
    logic [1:0] r_settle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qi <= '0;
            r_qj <= '0;
            r_qk <= '0;
            r_qr <= Q_UNIT;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_QI:  r_qi <= i_cfg_data;
                REG_QJ:  r_qj <= i_cfg_data;
                REG_QK:  r_qk <= i_cfg_data;
                REG_QR:  r_qr <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // products, then matrix: o_busy holds until a new quaternion is in r_mat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_settle <= 2'd2;
        end else if (r_settle != 2'd0) begin
            r_settle <= r_settle - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_ii <= r_qi * r_qi;
        r_p_jj <= r_qj * r_qj;
        r_p_kk <= r_qk * r_qk;
        r_p_ij <= r_qi * r_qj;
        r_p_ik <= r_qi * r_qk;
        r_p_jk <= r_qj * r_qk;
        r_p_ir <= r_qi * r_qr;
        r_p_jr <= r_qj * r_qr;
        r_p_kr <= r_qk * r_qr;
    end

    always_comb begin
        e_ii = M_W'(r_p_ii);
        e_jj = M_W'(r_p_jj);
        e_kk = M_W'(r_p_kk);
        e_ij = M_W'(r_p_ij);
        e_ik = M_W'(r_p_ik);
        e_jk = M_W'(r_p_jk);
        e_ir = M_W'(r_p_ir);
        e_jr = M_W'(r_p_jr);
        e_kr = M_W'(r_p_kr);

        n_mat[0][0] = M_ONE - ((e_jj + e_kk) <<< 1);
        n_mat[0][1] = (e_ij - e_kr) <<< 1;
        n_mat[0][2] = (e_ik + e_jr) <<< 1;
        n_mat[1][0] = (e_ij + e_kr) <<< 1;
        n_mat[1][1] = M_ONE - ((e_ii + e_kk) <<< 1);
        n_mat[1][2] = (e_jk - e_ir) <<< 1;
        n_mat[2][0] = (e_ik - e_jr) <<< 1;
        n_mat[2][1] = (e_jk + e_ir) <<< 1;
        n_mat[2][2] = M_ONE - ((e_ii + e_jj) <<< 1);
    end

    always_ff @(posedge i_clk) begin
        r_mat <= n_mat;
    end

    assign o_mat  = r_mat;
    assign o_busy = (r_settle != 2'd0);

endmodule

`default_nettype wire

// ----- design/qvr_lane.sv -----
// ----------------------------------------------------------------------------
// qvr_lane : one output component of the rotation
// Multiplies one matrix row by the vector, sums, rounds half up from Q.28
// and saturates to 24 bits. Two register stages, advanced by i_en.
// ----------------------------------------------------------------------------
`default_nettype none

module qvr_lane
    import qvr_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_en,
    input  wire t_mrow i_row,
    input  wire t_vec3 i_vec,
    output t_vec       o_val,
    output logic       o_sat
);

    logic signed [P_W-1:0]   r_prod [AXES];
    logic signed [ACC_W-1:0] acc;
    logic signed [RND_W-1:0] rnd;
    logic                    ovf;
    t_vec                    r_val, n_val;
    logic                    r_sat;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int a = 0; a < AXES; a++) begin
                r_prod[a] <= $signed(i_row[a]) * $signed(i_vec[a]);
            end
        end
    end

    always_comb begin
        acc = ACC_W'(r_prod[0]) + ACC_W'(r_prod[1]) + ACC_W'(r_prod[2]) + ACC_HALF;
        rnd = acc[ACC_W-1:FRAC_W];   // floor after adding one half
        ovf = (rnd[RND_W-1:VEC_W-1] != {(RND_W - VEC_W + 1){rnd[RND_W-1]}});
        if (!ovf) begin
            n_val = rnd[VEC_W-1:0];
        end else if (rnd[RND_W-1]) begin
            n_val = VEC_MIN;
        end else begin
            n_val = VEC_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_val <= n_val;
            r_sat <= ovf;
        end
    end

    assign o_val = r_val;
    assign o_sat = r_sat;

endmodule

`default_nettype wire

// ----- dv/quaternion_vector_rotate_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_tb : self-checking bench for the vector rotator
// Streams random and corner-case vectors through the block under several
// quaternion settings and checks every rotated item against a 64-bit
// fixed-point prediction of the rotation matrix product.
// ----------------------------------------------------------------------------

module quaternion_vector_rotate_tb;
    import qvr_pkg::*;

    localparam int    PHASES       = 12;
    localparam int    PHASE_ITEMS  = 128;
    localparam int    SETTLE_CYC   = 8;
    localparam t_quat Q_TOP        = 16'sh7FFF;
    localparam t_quat Q_BOTTOM     = 16'sh8000;
    localparam t_quat Q_COS45      = 16'sd11585;

    typedef struct {
        t_vec rot_x;
        t_vec rot_y;
        t_vec rot_z;
        logic sat;
    } t_rot_item;

    // ------------------------------------------------------------------
    // scoreboard: own copy of the quaternion, queue of expected items
    // ------------------------------------------------------------------
    class rotation_scoreboard;
        t_quat     quat [4];
        t_rot_item pending_rot [$];
        int        mismatches;

        function new();
            quat[REG_QI] = '0;
            quat[REG_QJ] = '0;
            quat[REG_QK] = '0;
            quat[REG_QR] = Q_UNIT;
            mismatches   = 0;
        endfunction

        function void write_reg(t_reg_idx idx, t_quat val);
            quat[idx] = val;
        endfunction

        function int pending();
            return pending_rot.size();
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            mismatches++;
        endtask

        // matrix in Q.28 from the Q2.14 quaternion, exact sums, round half up
        function t_rot_item rotate_vector(t_vec x, t_vec y, t_vec z);
            longint    qi, qj, qk, qr;
            longint    one, half, acc, r;
            longint    m [3][3];
            longint    v [3];
            t_vec      comp [3];
            t_rot_item res;
            qi   = quat[REG_QI];
            qj   = quat[REG_QJ];
            qk   = quat[REG_QK];
            qr   = quat[REG_QR];
            one  = longint'(1) <<< FRAC_W;
            half = one >>> 1;
            v[0] = x;
            v[1] = y;
            v[2] = z;
            m[0][0] = one - 2 * (qj * qj + qk * qk);
            m[0][1] = 2 * (qi * qj - qk * qr);
            m[0][2] = 2 * (qi * qk + qj * qr);
            m[1][0] = 2 * (qi * qj + qk * qr);
            m[1][1] = one - 2 * (qi * qi + qk * qk);
            m[1][2] = 2 * (qj * qk - qi * qr);
            m[2][0] = 2 * (qi * qk - qj * qr);
            m[2][1] = 2 * (qj * qk + qi * qr);
            m[2][2] = one - 2 * (qi * qi + qj * qj);
            res.sat = 1'b0;
            for (int a = 0; a < 3; a++) begin
                acc = m[a][0] * v[0] + m[a][1] * v[1] + m[a][2] * v[2];
                r   = (acc + half) >>> FRAC_W;   // arithmetic shift floors
                if (r > VEC_MAX) begin
                    r       = VEC_MAX;
                    res.sat = 1'b1;
                end
                if (r < VEC_MIN) begin
                    r       = VEC_MIN;
                    res.sat = 1'b1;
                end
                comp[a] = t_vec'(r);
            end
            res.rot_x = comp[0];
            res.rot_y = comp[1];
            res.rot_z = comp[2];
            return res;
        endfunction

        function void note_vector(logic [71:0] data);
            pending_rot.push_back(rotate_vector(t_vec'(data[0 +: VEC_W]),
                                                t_vec'(data[VEC_W +: VEC_W]),
                                                t_vec'(data[2*VEC_W +: VEC_W])));
        endfunction

        task compare(string name, longint got, longint want);
            if (got != want)
                report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
        endtask

        task check_result(logic [71:0] data, logic user);
            t_rot_item want;
            if (pending_rot.size() == 0) begin
                report_mismatch("rotated item with no vector outstanding");
                return;
            end
            want = pending_rot.pop_front();
            compare("rot_x", t_vec'(data[0 +: VEC_W]), want.rot_x);
            compare("rot_y", t_vec'(data[VEC_W +: VEC_W]), want.rot_y);
            compare("rot_z", t_vec'(data[2*VEC_W +: VEC_W]), want.rot_z);
            compare("saturated", user, want.sat);
        endtask
    endclass

    // ------------------------------------------------------------------
    // signals, clock, block
    // ------------------------------------------------------------------
    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [71:0] i_s_axis_tdata;    // vec_x, vec_y, vec_z
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [71:0] o_m_axis_tdata;    // rot_x, rot_y, rot_z
    logic        o_m_axis_tuser;    // saturated

    int src_idle_pct  = 0;
    int sink_idle_pct = 0;

    rotation_scoreboard sb = new();

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    quaternion_vector_rotate u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // sampled at the edge, before this edge's updates land
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we)
                sb.write_reg(t_reg_idx'(i_cfg_idx), t_quat'(i_cfg_data));
            if (i_s_axis_tvalid && o_s_axis_tready)
                sb.note_vector(i_s_axis_tdata);
            if (o_m_axis_tvalid && i_m_axis_tready)
                sb.check_result(o_m_axis_tdata, o_m_axis_tuser);
        end
    end

    // receiver: stalls in bursts while enabled
    initial begin
        i_m_axis_tready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (sink_idle_pct != 0 && $urandom_range(0, 99) < sink_idle_pct) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end else begin
                i_m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic send_vector(input t_vec x, input t_vec y, input t_vec z);
        if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {z, y, x};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    // stop sending and wait until every outstanding item has come back
    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_quat(input t_quat qi, input t_quat qj,
                              input t_quat qk, input t_quat qr);
        t_quat    vals [4];
        t_reg_idx idx;
        vals[REG_QI] = qi;
        vals[REG_QJ] = qj;
        vals[REG_QK] = qk;
        vals[REG_QR] = qr;
        idx = REG_QI;
        repeat (4) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx;
            i_cfg_data <= vals[idx];
            @(posedge i_clk);
            idx = idx.next();
        end
        i_cfg_we <= 1'b0;
    endtask

    // full range, plain extremes, unit steps and odd values for rounding
    task automatic send_directed();
        send_vector(VEC_MAX, VEC_MAX, VEC_MAX);
        send_vector(VEC_MIN, VEC_MIN, VEC_MIN);
        send_vector('0, '0, '0);
        send_vector(VEC_MAX, VEC_MIN, '0);
        send_vector(t_vec'(1), t_vec'(-1), t_vec'(3));
        send_vector(t_vec'(-3), t_vec'(5), t_vec'(-7));
        send_vector(VEC_MIN, t_vec'(1), VEC_MAX);
        send_vector(t_vec'(-1), t_vec'(-1), t_vec'(-1));
    endtask

    function automatic t_vec rand_component();
        case ($urandom_range(0, 19))
            0:       return VEC_MAX;
            1:       return VEC_MIN;
            2:       return '0;
            3:       return t_vec'(-1);
            4, 5, 6: return t_vec'($signed($urandom_range(0, 2000)) - 1000);
            default: return t_vec'($urandom());
        endcase
    endfunction

    function automatic t_quat corner_q();
        case ($urandom_range(0, 5))
            0:       return Q_TOP;
            1:       return Q_BOTTOM;
            2:       return Q_UNIT;
            3:       return -Q_UNIT;
            4:       return Q_COS45;
            default: return '0;
        endcase
    endfunction

    function automatic int pick_idle();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 8;
            default: return 25;
        endcase
    endfunction

    function automatic void choose_quat(input int p, output t_quat qi,
                                        output t_quat qj, output t_quat qk,
                                        output t_quat qr);
        real a, b, c, d, n;
        if (p == 0) begin
            qi = Q_BOTTOM; qj = Q_BOTTOM; qk = Q_BOTTOM; qr = Q_BOTTOM;
        end else if (p == 1) begin
            qi = Q_UNIT; qj = -Q_UNIT; qk = Q_UNIT; qr = -Q_UNIT;
        end else if (p == 2) begin
            // quarter turn about z
            qi = '0; qj = '0; qk = Q_COS45; qr = Q_COS45;
        end else begin
            case ($urandom_range(0, 2))
                0: begin
                    a = real'($urandom_range(0, 2000)) - 1000.0;
                    b = real'($urandom_range(0, 2000)) - 1000.0;
                    c = real'($urandom_range(0, 2000)) - 1000.0;
                    d = real'($urandom_range(0, 2000)) - 1000.0;
                    n = $sqrt(a * a + b * b + c * c + d * d);
                    if (n < 1.0) begin
                        d = 1000.0;
                        n = 1000.0;
                    end
                    qi = t_quat'($rtoi(a / n * 16384.0));
                    qj = t_quat'($rtoi(b / n * 16384.0));
                    qk = t_quat'($rtoi(c / n * 16384.0));
                    qr = t_quat'($rtoi(d / n * 16384.0));
                end
                1: begin
                    qi = t_quat'($urandom());
                    qj = t_quat'($urandom());
                    qk = t_quat'($urandom());
                    qr = t_quat'($urandom());
                end
                default: begin
                    qi = corner_q();
                    qj = corner_q();
                    qk = corner_q();
                    qr = corner_q();
                end
            endcase
        end
    endfunction

    initial begin
        t_quat qi, qj, qk, qr;
        bit    last;
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= REG_QI;
        i_cfg_data      <= '0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: identity at reset, half-scale axis, oversized quaternion
        src_idle_pct  = 15;
        sink_idle_pct = 15;
        send_directed();
        wait_drained();
        write_quat(16'sd8192, '0, '0, '0);
        send_directed();
        wait_drained();
        write_quat(Q_TOP, Q_TOP, Q_TOP, Q_TOP);
        send_directed();
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            last = (p == PHASES - 1);
            choose_quat(p, qi, qj, qk, qr);
            write_quat(qi, qj, qk, qr);
            src_idle_pct  = last ? 0 : pick_idle();
            sink_idle_pct = last ? 0 : pick_idle();
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2 && (p == 0 || $urandom_range(0, 3) == 0))
                    wait_drained();
                send_vector(rand_component(), rand_component(), rand_component());
            end
            wait_drained();
        end

        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d rotated items never arrived", sb.pending()));
        if (sb.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
design/qvr_pkg.sv
design/qvr_matrix.sv
design/qvr_lane.sv
design/quaternion_vector_rotate.sv
dv/quaternion_vector_rotate_tb.sv
